[hw/rtl/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the substring filter scan
// Beat layouts of the row and result channels, the register index codes and
// the pattern and limit configuration that the register file hands to the core.
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int TEXT_FIELD_BYTES = 44;
   localparam int PAT_MAX          = 43;
   localparam int PAD_BYTES        = TEXT_FIELD_BYTES + PAT_MAX;

   typedef logic [PAT_MAX-1:0][7:0]   pattern_type;
   typedef logic [PAD_BYTES-1:0][7:0] text_pad_type;

   typedef enum logic [2:0] {
      CSR_PAT_0   = 3'd0,
      CSR_PAT_1   = 3'd1,
      CSR_PAT_2   = 3'd2,
      CSR_PAT_3   = 3'd3,
      CSR_PAT_4   = 3'd4,
      CSR_PAT_5   = 3'd5,
      CSR_PAT_LEN = 3'd6,
      CSR_LIMIT   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic        first_row;
      logic [31:0] order_key;
      logic [31:0] part_key;
      logic [31:0] supplier_key;
      logic [63:0] text_word_0;
      logic [63:0] text_word_1;
      logic [63:0] text_word_2;
      logic [63:0] text_word_3;
      logic [63:0] text_word_4;
      logic [31:0] text_word_5;
   } req_data_type;

   typedef struct packed {
      logic        selected;
      logic        matched;
      logic [31:0] match_total;
      logic [31:0] out_order_key;
      logic [31:0] out_part_key;
      logic [31:0] out_supplier_key;
      logic [63:0] out_text_word_0;
      logic [63:0] out_text_word_1;
      logic [63:0] out_text_word_2;
      logic [63:0] out_text_word_3;
      logic [63:0] out_text_word_4;
      logic [31:0] out_text_word_5;
   } rsp_data_type;

   typedef struct packed {
      pattern_type        pattern;
      logic [PAT_MAX-1:0] mask;
      logic signed [31:0] limit;
   } cfg_type;

endpackage

[hw/rtl/substring_filter_scan_with_limit_core.sv]
// ----------------------------------------------------------------------------
// substring_filter_scan_with_limit_core: substring filter over table rows
// Each row beat carries three keys and a comment. One lane per start position
// compares the configured pattern against the comment in parallel, and the
// merge stage counts matches and applies the result limit.
//
// Usage:
//   req_*  : row beats (valid/ready). first_row restarts the match count.
//   rsp_*  : one result beat per row, in row order (valid/ready).
//   csr_*  : register writes (valid/ready, always ready); write only while
//            no row is in flight.
//   Each accepted row is registered in the lane compare register and then in
//   the merge/result register, which drives the result beat.
//   Throughput is one row per cycle while the receiver takes results; the serial
//   match count update in the merge stage is the only per-row dependency and fits in that cycle.
//   When the receiver stalls, the result register holds its beat and one
//   more row is taken into the lane register before req_ready drops.
//   Reset clears the match count, empties both stages, sets the pattern
//   registers to zero (empty pattern) and the limit to minus one (no limit).
// ----------------------------------------------------------------------------
module substring_filter_scan_with_limit_core #(
   parameter int TEXT_BYTES = 44
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sfs_pkg::req_data_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sfs_pkg::rsp_data_type  rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  sfs_pkg::csr_index_type csr_index,
   input  logic [63:0]            csr_data
);
   import sfs_pkg::*;

   localparam int NUM_LANES = (TEXT_BYTES < TEXT_FIELD_BYTES) ? TEXT_BYTES : TEXT_FIELD_BYTES;

   cfg_type                cfg;
   logic [8*TEXT_FIELD_BYTES-1:0] text_flat;
   logic [NUM_LANES-1:0]   text_live;
   text_pad_type           text_pad;
   logic [NUM_LANES-1:0]   hits;
   logic                   s1_valid_ff, s1_valid_in;
   logic [NUM_LANES-1:0]   s1_hits_ff;
   req_data_type           s1_data_ff;
   logic                   merge_ready;
   logic                   req_fire;

   sfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign text_flat = {req_data.text_word_5, req_data.text_word_4, req_data.text_word_3,
                       req_data.text_word_2, req_data.text_word_1, req_data.text_word_0};

   // A comment byte is live while no zero byte comes before it.
   assign text_live[0] = 1'b1;
   for (genvar b = 1; b < NUM_LANES; b++) begin : g_live
      assign text_live[b] = text_live[b-1] & (text_flat[8*(b-1) +: 8] != 8'd0);
   end

   // Bytes past the end of the comment read as zero and never equal a pattern byte.
   for (genvar b = 0; b < PAD_BYTES; b++) begin : g_pad
      if (b < NUM_LANES) begin : g_text
         assign text_pad[b] = text_live[b] ? text_flat[8*b +: 8] : 8'd0;
      end else begin : g_zero
         assign text_pad[b] = 8'd0;
      end
   end

   for (genvar s = 0; s < NUM_LANES; s++) begin : g_lane
      sfs_lane #(
         .START (s)
      ) u_lane (
         .text_pad (text_pad),
         .pattern  (cfg.pattern),
         .mask     (cfg.mask),
         .hit      (hits[s])
      );
   end

   assign req_ready   = ~s1_valid_ff | merge_ready;
   assign req_fire    = req_valid & req_ready;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_hits_ff <= hits;
         s1_data_ff <= req_data;
      end
   end

   sfs_merge #(
      .NUM_LANES (NUM_LANES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (merge_ready),
      .in_hits   (s1_hits_ff),
      .in_data   (s1_data_ff),
      .limit     (cfg.limit),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_selected_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.selected |-> rsp_data.matched)
      else $error("selected row without a match");

   a_match_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.matched |-> rsp_data.match_total != 32'd0)
      else $error("matched row with a zero match total");

   a_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.selected && !cfg.limit[31]
      |-> rsp_data.match_total <= unsigned'(cfg.limit))
      else $error("selected row beyond the result limit");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("row channel stalled with an empty lane stage");
`endif

endmodule

[hw/rtl/sfs_csr.sv]
// ----------------------------------------------------------------------------
// sfs_csr: configuration registers
// Holds the pattern bytes, pattern length and result limit, and derives the
// mask of pattern bytes in use (up to the length or the first zero byte).
// ----------------------------------------------------------------------------
module sfs_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  sfs_pkg::csr_index_type csr_index,
   input  logic [63:0]           csr_data,
   output sfs_pkg::cfg_type      cfg
);
   import sfs_pkg::*;

   pattern_type        pat_ff, pat_in;
   logic [5:0]         len_ff, len_in;
   logic signed [31:0] limit_ff, limit_in;
   logic [PAT_MAX-1:0] mask;

   assign csr_ready = 1'b1;

   always_comb begin
      pat_in   = pat_ff;
      len_in   = len_ff;
      limit_in = limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PAT_0:   pat_in[7:0]   = csr_data;
            CSR_PAT_1:   pat_in[15:8]  = csr_data;
            CSR_PAT_2:   pat_in[23:16] = csr_data;
            CSR_PAT_3:   pat_in[31:24] = csr_data;
            CSR_PAT_4:   pat_in[39:32] = csr_data;
            CSR_PAT_5:   pat_in[42:40] = csr_data[23:0];
            CSR_PAT_LEN: len_in        = csr_data[5:0];
            CSR_LIMIT:   limit_in      = signed'(csr_data[31:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff   <= '0;
         len_ff   <= '0;
         limit_ff <= -32'sd1;
      end else begin
         pat_ff   <= pat_in;
         len_ff   <= len_in;
         limit_ff <= limit_in;
      end
   end

   // A byte is in use while it lies below the length and no zero byte precedes it.
   always_comb begin
      logic alive;
      alive = 1'b1;
      for (int k = 0; k < PAT_MAX; k++) begin
         alive   = alive & (pat_ff[k] != 8'd0);
         mask[k] = alive & (6'(k) < len_ff);
      end
   end

   assign cfg.pattern = pat_ff;
   assign cfg.mask    = mask;
   assign cfg.limit   = limit_ff;

endmodule

[hw/rtl/sfs_lane.sv]
// ----------------------------------------------------------------------------
// sfs_lane: pattern compare at one start position
// Compares every pattern byte in use against the comment bytes that follow
// the lane's start position and reports whether all of them agree.
// ----------------------------------------------------------------------------
module sfs_lane #(
   parameter int START = 0
) (
   input  sfs_pkg::text_pad_type text_pad,
   input  sfs_pkg::pattern_type  pattern,
   input  logic [sfs_pkg::PAT_MAX-1:0] mask,
   output logic                  hit
);
   import sfs_pkg::*;

   logic [PAT_MAX-1:0] agree;

   always_comb begin
      for (int k = 0; k < PAT_MAX; k++) begin
         agree[k] = ~mask[k] | (text_pad[START + k] == pattern[k]);
      end
   end

   assign hit = &agree;

endmodule

[hw/rtl/sfs_merge.sv]
// ----------------------------------------------------------------------------
// sfs_merge: lane merge, match count and result register
// Combines the lane hits of one row, updates the saturating match count,
// applies the result limit and holds the result beat for the receiver.
// ----------------------------------------------------------------------------
module sfs_merge #(
   parameter int NUM_LANES = 44
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [NUM_LANES-1:0]  in_hits,
   input  sfs_pkg::req_data_type in_data,
   input  logic signed [31:0]    limit,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sfs_pkg::rsp_data_type rsp_data
);
   import sfs_pkg::*;

   logic         out_valid_ff, out_valid_in;
   rsp_data_type out_data_ff, out_data_in;
   logic [31:0]  count_ff, count_in;
   logic [31:0]  count_base;
   logic         matched;
   logic         fire;

   assign in_ready = ~out_valid_ff | rsp_ready;
   assign fire     = in_valid & in_ready;
   assign matched  = |in_hits;

   always_comb begin
      count_base = in_data.first_row ? 32'd0 : count_ff;
      count_in   = count_base;
      if (matched && count_base != 32'hFFFF_FFFF) begin
         count_in = count_base + 32'd1;
      end
      out_data_in.selected         = matched & (limit[31] | (count_in <= unsigned'(limit)));
      out_data_in.matched          = matched;
      out_data_in.match_total      = count_in;
      out_data_in.out_order_key    = in_data.order_key;
      out_data_in.out_part_key     = in_data.part_key;
      out_data_in.out_supplier_key = in_data.supplier_key;
      out_data_in.out_text_word_0  = in_data.text_word_0;
      out_data_in.out_text_word_1  = in_data.text_word_1;
      out_data_in.out_text_word_2  = in_data.text_word_2;
      out_data_in.out_text_word_3  = in_data.text_word_3;
      out_data_in.out_text_word_4  = in_data.text_word_4;
      out_data_in.out_text_word_5  = in_data.text_word_5;
      out_valid_in = in_ready ? in_valid : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[dv/substring_filter_scan_with_limit_core_tb.sv]
// ----------------------------------------------------------------------------
// substring_filter_scan_with_limit_core_tb: self-checking bench of the scan core
// A short table of rows and register writes covers the pattern and comment
// edge cases, the limit extremes and the first-row restart. Random query
// phases with fresh pattern settings follow. Every result beat is compared
// field by field against a local model of the substring match, the running
// match count and the limit, or against the outcome typed into its table row.
// Both sides idle at random, and the receiver also holds off for long stretches.
// ----------------------------------------------------------------------------
module substring_filter_scan_with_limit_core_tb;
   import sfs_pkg::*;

   typedef logic [TEXT_FIELD_BYTES-1:0][7:0] comment_bytes_type;
   typedef enum logic {STEP_ROW, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      csr_index_type reg_index;
      logic [63:0]   reg_value;
      req_data_type  row;
      logic          typed;
      logic          t_selected;
      logic          t_matched;
      logic [31:0]   t_total;
   } scan_step_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_data_type  req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_data_type  rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_PAT_0;
   logic [63:0]   csr_data = '0;

   logic [63:0]   pat_word [6];
   logic [5:0]    pat_len_reg;
   logic [31:0]   limit_reg;
   logic [31:0]   match_count;

   rsp_data_type  pending_results [$];
   scan_step_type directed_plan [$];
   int            fail_count = 0;
   int            row_idle_pct = 25;
   int            rsp_idle_pct = 25;
   bit            hold_request = 1'b0;

   substring_filter_scan_with_limit_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic pattern_type pattern_image();
      return {pat_word[5][23:0], pat_word[4], pat_word[3], pat_word[2], pat_word[1],
              pat_word[0]};
   endfunction

   function automatic int active_pattern_len();
      pattern_type pat;
      int n;
      int i;
      pat = pattern_image();
      n = pat_len_reg;
      if (n > PAT_MAX) begin
         n = PAT_MAX;
      end
      i = 0;
      while (i < n && pat[i] != 8'h00) i++;
      return i;
   endfunction

   function automatic void mirror_csr(csr_index_type idx, logic [63:0] value);
      case (idx)
         CSR_PAT_0: begin
            pat_word[0] = value;
         end
         CSR_PAT_1: begin
            pat_word[1] = value;
         end
         CSR_PAT_2: begin
            pat_word[2] = value;
         end
         CSR_PAT_3: begin
            pat_word[3] = value;
         end
         CSR_PAT_4: begin
            pat_word[4] = value;
         end
         CSR_PAT_5: begin
            pat_word[5] = {40'h0, value[23:0]};
         end
         CSR_PAT_LEN: begin
            pat_len_reg = value[5:0];
         end
         CSR_LIMIT: begin
            limit_reg = value[31:0];
         end
      endcase
   endfunction

   function automatic rsp_data_type predict_scan(req_data_type r);
      comment_bytes_type txt;
      pattern_type       pat;
      int                tlen;
      int                plen;
      int                s;
      int                k;
      bit                hit;
      rsp_data_type      res;
      txt = {r.text_word_5, r.text_word_4, r.text_word_3, r.text_word_2, r.text_word_1,
             r.text_word_0};
      pat = pattern_image();
      tlen = 0;
      while (tlen < TEXT_FIELD_BYTES && txt[tlen] != 8'h00) tlen++;
      plen = active_pattern_len();
      if (r.first_row) begin
         match_count = '0;
      end
      hit = (plen == 0);
      for (s = 0; s + plen <= tlen && !hit; s++) begin
         hit = 1'b1;
         for (k = 0; k < plen; k++) begin
            if (txt[s + k] != pat[k]) begin
               hit = 1'b0;
            end
         end
      end
      if (hit && match_count != 32'hFFFF_FFFF) begin
         match_count++;
      end
      res = '0;
      res.selected = hit && (limit_reg[31] || match_count <= limit_reg);
      res.matched = hit;
      res.match_total = match_count;
      res.out_order_key = r.order_key;
      res.out_part_key = r.part_key;
      res.out_supplier_key = r.supplier_key;
      res.out_text_word_0 = r.text_word_0;
      res.out_text_word_1 = r.text_word_1;
      res.out_text_word_2 = r.text_word_2;
      res.out_text_word_3 = r.text_word_3;
      res.out_text_word_4 = r.text_word_4;
      res.out_text_word_5 = r.text_word_5;
      return res;
   endfunction

   function automatic req_data_type pack_row(bit first, comment_bytes_type txt);
      req_data_type r;
      r.first_row = first;
      r.order_key = $urandom;
      r.part_key = $urandom;
      r.supplier_key = $urandom;
      r.text_word_0 = txt[7:0];
      r.text_word_1 = txt[15:8];
      r.text_word_2 = txt[23:16];
      r.text_word_3 = txt[31:24];
      r.text_word_4 = txt[39:32];
      r.text_word_5 = txt[43:40];
      return r;
   endfunction

   // A dot in the string stands for a zero byte.
   function automatic scan_step_type row_step(bit first, string s);
      comment_bytes_type txt;
      scan_step_type     st;
      int                i;
      txt = '0;
      for (i = 0; i < s.len() && i < TEXT_FIELD_BYTES; i++) begin
         txt[i] = (s[i] == ".") ? 8'h00 : s[i];
      end
      st = '0;
      st.kind = STEP_ROW;
      st.row = pack_row(first, txt);
      return st;
   endfunction

   function automatic scan_step_type typed_row(bit first, string s, bit sel, bit hit,
                                               logic [31:0] total);
      scan_step_type st;
      st = row_step(first, s);
      st.typed = 1'b1;
      st.t_selected = sel;
      st.t_matched = hit;
      st.t_total = total;
      return st;
   endfunction

   function automatic scan_step_type reg_step(csr_index_type idx, logic [63:0] value);
      scan_step_type st;
      st = '0;
      st.kind = STEP_CSR;
      st.reg_index = idx;
      st.reg_value = value;
      return st;
   endfunction

   function automatic string repeat_char(string c, int n);
      string s;
      s = "";
      repeat (n) s = {s, c};
      return s;
   endfunction

   function automatic scan_step_type random_step();
      comment_bytes_type txt;
      pattern_type       pat;
      scan_step_type     st;
      int                plen;
      int                mode;
      int                off;
      int                i;
      pat = pattern_image();
      plen = active_pattern_len();
      mode = $urandom_range(9);
      if (mode == 0) begin
         for (i = 0; i < TEXT_FIELD_BYTES; i++) txt[i] = 8'($urandom);
      end else begin
         for (i = 0; i < TEXT_FIELD_BYTES; i++) txt[i] = 8'(8'h61 + $urandom_range(2));
         if (mode <= 6) begin
            off = $urandom_range(TEXT_FIELD_BYTES - plen);
            for (i = 0; i < plen; i++) txt[off + i] = pat[i];
         end
         if ($urandom_range(3) == 0) begin
            txt[$urandom_range(TEXT_FIELD_BYTES - 1)] = 8'h00;
         end
      end
      st = '0;
      st.kind = STEP_ROW;
      st.row = pack_row($urandom_range(19) == 0, txt);
      return st;
   endfunction

   task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result(rsp_data_type got);
      rsp_data_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: result beat with none expected, actual %h", $time, got);
         fail_count++;
      end else begin
         want = pending_results.pop_front();
         compare_field("selected", got.selected, want.selected);
         compare_field("matched", got.matched, want.matched);
         compare_field("match_total", got.match_total, want.match_total);
         compare_field("out_order_key", got.out_order_key, want.out_order_key);
         compare_field("out_part_key", got.out_part_key, want.out_part_key);
         compare_field("out_supplier_key", got.out_supplier_key, want.out_supplier_key);
         compare_field("out_text_word_0", got.out_text_word_0, want.out_text_word_0);
         compare_field("out_text_word_1", got.out_text_word_1, want.out_text_word_1);
         compare_field("out_text_word_2", got.out_text_word_2, want.out_text_word_2);
         compare_field("out_text_word_3", got.out_text_word_3, want.out_text_word_3);
         compare_field("out_text_word_4", got.out_text_word_4, want.out_text_word_4);
         compare_field("out_text_word_5", got.out_text_word_5, want.out_text_word_5);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      mirror_csr(idx, value);
   endtask

   task automatic send_row(scan_step_type st);
      rsp_data_type want;
      csr_valid <= 1'b0;
      while ($urandom_range(99) < row_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= st.row;
      do @(posedge clock); while (!req_ready);
      want = predict_scan(st.row);
      if (st.typed) begin
         want.selected = st.t_selected;
         want.matched = st.t_matched;
         want.match_total = st.t_total;
      end
      pending_results.push_back(want);
   endtask

   task automatic program_random_config();
      pattern_type pat;
      logic [63:0] value;
      logic [31:0] lim;
      int          n;
      int          i;
      for (i = 0; i < PAT_MAX; i++) pat[i] = 8'(8'h61 + $urandom_range(2));
      if ($urandom_range(4) == 0) begin
         for (i = 0; i < PAT_MAX; i++) pat[i] = 8'($urandom);
      end
      if ($urandom_range(3) == 0) begin
         pat[$urandom_range(PAT_MAX - 1)] = 8'h00;
      end
      case ($urandom_range(4))
         0: n = 0;
         1: n = $urandom_range(1, 3);
         2: n = $urandom_range(4, 8);
         3: n = $urandom_range(30, PAT_MAX);
         default: n = $urandom_range(PAT_MAX + 1, 63);
      endcase
      case ($urandom_range(5))
         0: lim = 32'hFFFF_FFFF;
         1: lim = 32'h0;
         2: lim = $urandom_range(1, 30);
         3: lim = 32'h7FFF_FFFF;
         4: lim = {1'b1, 31'($urandom)};
         default: lim = $urandom;
      endcase
      write_reg(CSR_PAT_0, pat[7:0]);
      write_reg(CSR_PAT_1, pat[15:8]);
      write_reg(CSR_PAT_2, pat[23:16]);
      write_reg(CSR_PAT_3, pat[31:24]);
      write_reg(CSR_PAT_4, pat[39:32]);
      value = {$urandom, $urandom};
      value[23:0] = pat[42:40];
      write_reg(CSR_PAT_5, value);
      value = {$urandom, $urandom};
      value[5:0] = n[5:0];
      write_reg(CSR_PAT_LEN, value);
      write_reg(CSR_LIMIT, {$urandom, lim});
   endtask

   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
         end
         if (hold_request) begin
            hold_left = $urandom_range(40, 80);
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin : stimulus
      scan_step_type st;
      int            phase;
      for (int i = 0; i < 6; i++) pat_word[i] = '0;
      pat_len_reg = '0;
      limit_reg = 32'hFFFF_FFFF;
      match_count = '0;

      st = typed_row(1'b0, "", 1'b1, 1'b1, 32'd1);
      st.row.order_key = '0;
      st.row.part_key = '0;
      st.row.supplier_key = '0;
      directed_plan.push_back(st);
      st = typed_row(1'b0, "", 1'b1, 1'b1, 32'd2);
      st.row.order_key = '1;
      st.row.part_key = '1;
      st.row.supplier_key = '1;
      st.row.text_word_0 = '1;
      st.row.text_word_1 = '1;
      st.row.text_word_2 = '1;
      st.row.text_word_3 = '1;
      st.row.text_word_4 = '1;
      st.row.text_word_5 = '1;
      directed_plan.push_back(st);
      directed_plan.push_back(typed_row(1'b1, "hello", 1'b1, 1'b1, 32'd1));
      directed_plan.push_back(reg_step(CSR_PAT_0, 64'h0000_0000_0063_6261));
      directed_plan.push_back(reg_step(CSR_PAT_LEN, 64'd3));
      directed_plan.push_back(reg_step(CSR_LIMIT, 64'd1));
      directed_plan.push_back(row_step(1'b1, "xxabcx"));
      directed_plan.push_back(row_step(1'b0, {repeat_char("z", 41), "abc"}));
      directed_plan.push_back(row_step(1'b0, "ab.abc"));
      directed_plan.push_back(row_step(1'b0, "ab"));
      directed_plan.push_back(row_step(1'b0, ""));
      directed_plan.push_back(reg_step(CSR_PAT_0, 64'h4141_4141_4141_4141));
      directed_plan.push_back(reg_step(CSR_PAT_1, 64'h4141_4141_4141_4141));
      directed_plan.push_back(reg_step(CSR_PAT_2, 64'h4141_4141_4141_4141));
      directed_plan.push_back(reg_step(CSR_PAT_3, 64'h4141_4141_4141_4141));
      directed_plan.push_back(reg_step(CSR_PAT_4, 64'h4141_4141_4141_4141));
      directed_plan.push_back(reg_step(CSR_PAT_5, 64'hFFFF_FFFF_FF41_4141));
      directed_plan.push_back(reg_step(CSR_PAT_LEN, 64'd63));
      directed_plan.push_back(reg_step(CSR_LIMIT, 64'd0));
      directed_plan.push_back(typed_row(1'b1, repeat_char("A", 44), 1'b0, 1'b1, 32'd1));
      directed_plan.push_back(row_step(1'b0, {repeat_char("A", 43), "B"}));
      directed_plan.push_back(row_step(1'b0, {"B", repeat_char("A", 43)}));
      directed_plan.push_back(row_step(1'b0, {repeat_char("A", 42), "BA"}));
      directed_plan.push_back(row_step(1'b0, repeat_char("A", 42)));
      directed_plan.push_back(reg_step(CSR_PAT_0, 64'h0000_0000_6400_6261));
      directed_plan.push_back(reg_step(CSR_PAT_LEN, 64'd4));
      directed_plan.push_back(reg_step(CSR_LIMIT, 64'hFFFF_FFFF_7FFF_FFFF));
      directed_plan.push_back(row_step(1'b0, "zab"));
      directed_plan.push_back(row_step(1'b0, "a.b"));
      directed_plan.push_back(reg_step(CSR_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFC0));
      directed_plan.push_back(reg_step(CSR_LIMIT, 64'h0000_0000_8000_0000));
      directed_plan.push_back(typed_row(1'b1, "", 1'b1, 1'b1, 32'd1));
      directed_plan.push_back(reg_step(CSR_LIMIT, 64'd2));
      directed_plan.push_back(row_step(1'b0, "q"));
      directed_plan.push_back(row_step(1'b0, "q"));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_CSR) begin
            wait_drained();
            write_reg(directed_plan[i].reg_index, directed_plan[i].reg_value);
         end else begin
            send_row(directed_plan[i]);
         end
      end

      for (phase = 0; phase < 7; phase++) begin
         wait_drained();
         program_random_config();
         row_idle_pct = (phase == 2) ? 0 : 25;
         rsp_idle_pct = (phase == 2) ? 0 : 25;
         if (phase == 1 || phase == 4) begin
            hold_request = 1'b1;
         end
         repeat (100) send_row(random_step());
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_csr.sv
hw/rtl/sfs_lane.sv
hw/rtl/sfs_merge.sv
hw/rtl/substring_filter_scan_with_limit_core.sv
dv/substring_filter_scan_with_limit_core_tb.sv
